/* rtl/core/prnc_pkg.sv */
package prnc_pkg;

  // Field widths
  localparam int COORD_W = 16;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 6;
  localparam int SUM_W   = 12;
  localparam int FILL_W  = 7;
  localparam int CUT_W   = 32;
  localparam int SQ_W    = 2 * COORD_W;

  // Register file
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_BOX    = 1'b0;
  localparam logic REG_CUTOFF = 1'b1;
  localparam logic [COORD_W-1:0] BOX_RESET = 16'd10240;
  localparam logic [CUT_W-1:0]   CUT_RESET = 32'd1048576;

  // Cycles to empty the pair pipeline after the last rotation
  localparam int DRAIN_W = 2;
  localparam logic [DRAIN_W-1:0] DRAIN_LAST = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic [IDX_W-1:0] point_index;
    logic [CNT_W-1:0] neighbor_total;
    logic [SUM_W-1:0] degree_sum;
    logic             last_result;
  } result_t;

  // Point as it travels between cells
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } move_t;

  // Sequencer controls broadcast to every cell
  typedef struct packed {
    logic              write_en;
    logic [FILL_W-1:0] write_idx;
    logic [FILL_W-1:0] n_points;
    logic              prep;
    logic              rotate;
    logic              rot_first;
    logic              pair_en;
    logic              emit;
  } ctrl_t;

endpackage

/* rtl/core/prnc_cell.sv */
module prnc_cell #(
  parameter int INDEX      = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  prnc_pkg::ctrl_t                ctrl,
  input  logic [prnc_pkg::COORD_W-1:0]   box,
  input  logic [prnc_pkg::CUT_W-1:0]     cutoff,
  input  logic [prnc_pkg::COORD_W-1:0]   wr_x,
  input  logic [prnc_pkg::COORD_W-1:0]   wr_y,
  input  prnc_pkg::move_t                stat_prev,
  input  prnc_pkg::move_t                mov_prev,
  output prnc_pkg::move_t                stat_out,
  output prnc_pkg::move_t                mov_out,
  input  logic [prnc_pkg::CNT_W-1:0]     cnt_in,
  output logic [prnc_pkg::CNT_W-1:0]     cnt_out
);

  localparam logic [prnc_pkg::FILL_W-1:0] MY_IDX = prnc_pkg::FILL_W'(INDEX);

  // Saturate a coordinate to one LSB below the box side
  function automatic logic [prnc_pkg::COORD_W-1:0] clamp_coord(
    input logic [prnc_pkg::COORD_W-1:0] c,
    input logic [prnc_pkg::COORD_W-1:0] b
  );
    logic [prnc_pkg::COORD_W-1:0] r;
    if (b == '0) begin
      r = '0;
    end else if (c >= b) begin
      r = b - 1'b1;
    end else begin
      r = c;
    end
    return r;
  endfunction

  // Minimum-image magnitude of m - s
  function automatic logic [prnc_pkg::COORD_W-1:0] fold_abs(
    input logic [prnc_pkg::COORD_W-1:0] m,
    input logic [prnc_pkg::COORD_W-1:0] s,
    input logic [prnc_pkg::COORD_W-1:0] b
  );
    logic signed [prnc_pkg::COORD_W+1:0] d;
    logic signed [prnc_pkg::COORD_W+1:0] twice;
    logic signed [prnc_pkg::COORD_W+1:0] lim;
    logic signed [prnc_pkg::COORD_W+1:0] f;
    d     = $signed({2'b00, m}) - $signed({2'b00, s});
    twice = d <<< 1;
    lim   = $signed({2'b00, b});
    if (twice > lim) begin
      f = d - lim;
    end else if (twice < -lim) begin
      f = d + lim;
    end else begin
      f = d;
    end
    if (f < 0) begin
      f = -f;
    end
    return f[prnc_pkg::COORD_W-1:0];
  endfunction

  logic [prnc_pkg::COORD_W-1:0] sx, sy;
  logic                         svalid;
  prnc_pkg::move_t              mov;
  logic                         a_valid, b_valid;
  logic [prnc_pkg::COORD_W-1:0] a_dx, a_dy;
  logic [prnc_pkg::SQ_W-1:0]    b_sqx, b_sqy;
  logic [prnc_pkg::SQ_W:0]      d2;
  logic                         hit;
  logic [prnc_pkg::CNT_W-1:0]   cnt;

  // Resident point: loaded on its own index, saturated before the sweep
  always_ff @(posedge clk) begin
    if (ctrl.write_en && ctrl.write_idx == MY_IDX) begin
      sx <= wr_x;
      sy <= wr_y;
    end else if (ctrl.prep) begin
      sx <= clamp_coord(sx, box);
      sy <= clamp_coord(sy, box);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      svalid <= 1'b0;
    end else if (ctrl.prep) begin
      svalid <= MY_IDX < ctrl.n_points;
    end
  end

  // Traveling point: first takes the left neighbor's resident, then rotates
  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      mov <= ctrl.rot_first ? stat_prev : mov_prev;
    end
  end

  // Pair pipeline: fold, square, compare
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= ctrl.pair_en && svalid && mov.valid;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_dx  <= fold_abs(mov.x, sx, box);
    a_dy  <= fold_abs(mov.y, sy, box);
    b_sqx <= prnc_pkg::SQ_W'(a_dx) * prnc_pkg::SQ_W'(a_dx);
    b_sqy <= prnc_pkg::SQ_W'(a_dy) * prnc_pkg::SQ_W'(a_dy);
  end

  assign d2  = {1'b0, b_sqx} + {1'b0, b_sqy};
  assign hit = d2 <= {1'b0, cutoff};

  // Neighbor count; shifts toward cell 0 while results go out
  always_ff @(posedge clk) begin
    priority if (ctrl.prep) begin
      cnt <= '0;
    end else if (ctrl.emit) begin
      cnt <= cnt_in;
    end else if (b_valid && hit) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign stat_out = '{valid: svalid, x: sx, y: sy};
  assign mov_out  = mov;
  assign cnt_out  = cnt;

endmodule

/* rtl/core/periodic_radius_neighbor_count.sv */
// A point without the last mark is stored if the store has room, and busy stays low.
// A last-marked point starts the sweep: the prep state, MAX_POINTS-1 ring rotations,
// then the drain state; results follow one per cycle and are never stalled,
// n results for n stored points.
// While busy is high no point is accepted; loading resumes once the last result is registered.
// Sync reset empties the store and restores both registers.
module periodic_radius_neighbor_count #(
  parameter int MAX_POINTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  prnc_pkg::point_t              point,
  output logic                          result_valid,
  output prnc_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prnc_pkg::PADDR_W-1:0]  paddr,
  input  logic [prnc_pkg::PDATA_W-1:0]  pwdata,
  output logic [prnc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int LOAD_W = $clog2(MAX_POINTS + 1);
  localparam int STEP_W = $clog2(MAX_POINTS);
  localparam logic [LOAD_W-1:0] FULL     = LOAD_W'(MAX_POINTS);
  localparam logic [STEP_W-1:0] ROT_LAST = STEP_W'(MAX_POINTS - 2);

  typedef enum logic [2:0] {S_LOAD, S_PREP, S_ROTATE, S_DRAIN, S_EMIT} state_t;

  state_t                           state;
  logic [STEP_W-1:0]                step;
  logic [prnc_pkg::DRAIN_W-1:0]     drain_cnt;
  logic [LOAD_W-1:0]                points_loaded;
  logic [LOAD_W-1:0]                last_idx;
  logic                             pair_en;
  logic [prnc_pkg::SUM_W-1:0]       acc, acc_next;
  logic                             accepted, wr_en, emit_last;
  logic [prnc_pkg::COORD_W-1:0]     box_length;
  logic [prnc_pkg::CUT_W-1:0]       cutoff_squared;
  logic                             reg_sel, cfg_wr;
  prnc_pkg::ctrl_t                  ctrl;

  prnc_pkg::move_t                  stat_w [MAX_POINTS];
  prnc_pkg::move_t                  mov_w  [MAX_POINTS];
  logic [prnc_pkg::CNT_W-1:0]       cnt_w  [MAX_POINTS];

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_length     <= prnc_pkg::BOX_RESET;
      cutoff_squared <= prnc_pkg::CUT_RESET;
    end else if (cfg_wr) begin
      if (reg_sel == prnc_pkg::REG_BOX) begin
        box_length <= pwdata[prnc_pkg::COORD_W-1:0];
      end else begin
        cutoff_squared <= pwdata;
      end
    end
  end

  assign prdata = (reg_sel == prnc_pkg::REG_CUTOFF) ? cutoff_squared
                : {{(prnc_pkg::PDATA_W - prnc_pkg::COORD_W){1'b0}}, box_length};

  // Sequencer
  assign busy      = state != S_LOAD;
  assign accepted  = start && !busy;
  assign wr_en     = points_loaded < FULL;
  assign last_idx  = points_loaded - LOAD_W'(1);
  assign emit_last = LOAD_W'(step) == last_idx;
  assign acc_next  = acc + prnc_pkg::SUM_W'(cnt_w[0]);

  always_comb begin
    ctrl           = '0;
    ctrl.write_en  = accepted && wr_en;
    ctrl.write_idx = prnc_pkg::FILL_W'(points_loaded);
    ctrl.n_points  = prnc_pkg::FILL_W'(points_loaded);
    ctrl.prep      = state == S_PREP;
    ctrl.rotate    = state == S_ROTATE;
    ctrl.rot_first = (state == S_ROTATE) && (step == '0);
    ctrl.pair_en   = pair_en;
    ctrl.emit      = state == S_EMIT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      points_loaded <= '0;
      pair_en       <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      pair_en      <= state == S_ROTATE;
      unique case (state)
        S_LOAD: begin
          if (accepted) begin
            if (wr_en) begin
              points_loaded <= points_loaded + LOAD_W'(1);
            end
            if (point.last_point) begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          state <= S_ROTATE;
          step  <= '0;
          acc   <= '0;
        end
        S_ROTATE: begin
          if (step == ROT_LAST) begin
            state     <= S_DRAIN;
            drain_cnt <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DRAIN: begin
          if (drain_cnt == prnc_pkg::DRAIN_LAST) begin
            state <= S_EMIT;
            step  <= '0;
          end else begin
            drain_cnt <= drain_cnt + 1'b1;
          end
        end
        S_EMIT: begin
          result_valid          <= 1'b1;
          result.point_index    <= prnc_pkg::IDX_W'(step);
          result.neighbor_total <= cnt_w[0];
          result.degree_sum     <= emit_last ? acc_next : '0;
          result.last_result    <= emit_last;
          acc                   <= acc_next;
          if (emit_last) begin
            state         <= S_LOAD;
            points_loaded <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Ring of cells, one stored point each
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    localparam int PREV = (k == 0) ? MAX_POINTS - 1 : k - 1;
    logic [prnc_pkg::CNT_W-1:0] cnt_next;
    if (k == MAX_POINTS - 1) begin : g_tail
      assign cnt_next = '0;
    end else begin : g_mid
      assign cnt_next = cnt_w[k+1];
    end
    prnc_cell #(
      .INDEX      (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .box       (box_length),
      .cutoff    (cutoff_squared),
      .wr_x      (point.x_pos),
      .wr_y      (point.y_pos),
      .stat_prev (stat_w[PREV]),
      .mov_prev  (mov_w[PREV]),
      .stat_out  (stat_w[k]),
      .mov_out   (mov_w[k]),
      .cnt_in    (cnt_next),
      .cnt_out   (cnt_w[k])
    );
  end

  // Checks
  a_busy_on_last: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && point.last_point))
    else $error("sweep started without a last-marked point");

  a_result_in_sweep: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result transfer outside the output phase");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    points_loaded <= FULL)
    else $error("point store overfilled");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_result |=> !result_valid)
    else $error("result transfer after the last result");

endmodule
